>>> hdl/vpsb_pkg.sv
// Shared types, constants and the arctangent table of the waypoint steering unit.
package vpsb_pkg;

	localparam int SCAN_SIZE_DEF     = 1080;
	localparam int WINDOW_FIRST_DEF  = 520;
	localparam int WINDOW_END_DEF    = 559;
	localparam int MAX_WAYPOINTS_DEF = 256;
	localparam int QUEUE_DEPTH       = 4;

	localparam logic [2:0] REG_MAX_SPEED   = 3'd0;
	localparam logic [2:0] REG_MAX_STEER   = 3'd1;
	localparam logic [2:0] REG_MAX_DECEL   = 3'd2;
	localparam logic [2:0] REG_BRAKE_SPEED = 3'd3;
	localparam logic [2:0] REG_GAIN_P      = 3'd4;
	localparam logic [2:0] REG_GAIN_I      = 3'd5;
	localparam logic [2:0] REG_GAIN_D      = 3'd6;

	typedef enum logic [1:0] {
		CMD_LOAD  = 2'd0,
		CMD_RANGE = 2'd1,
		CMD_ODO   = 2'd2,
		CMD_NONE  = 2'd3
	} cmd_t;

	typedef struct packed {
		cmd_t               cmd;
		logic               last;
		logic [15:0]        range_mm;
		logic signed [23:0] pos_x;
		logic signed [23:0] pos_y;
		logic signed [15:0] heading;
		logic signed [15:0] speed;
	} item_t;

	typedef struct packed {
		logic        we;
		logic [2:0]  idx;
		logic [15:0] data;
	} cfg_wr_t;

	typedef enum logic [4:0] {
		S_IDLE, S_LOAD_RD, S_LOAD_TGT,
		S_SCAN_V2, S_SCAN_T2, S_SCAN_N1, S_SCAN_N2, S_SCAN_DIV, S_SCAN_FIN,
		S_ODO_D, S_ODO_X2, S_ODO_Y2, S_ODO_T2, S_ODO_REACH, S_ODO_RD, S_ODO_TGT,
		S_COR_INIT, S_COR_RUN, S_PID_E, S_PID_P, S_PID_I, S_PID_D, S_OUT
	} state_t;

	function automatic logic [31:0] atan_val(input logic [4:0] i);
		logic [31:0] r;
		case (i)
			5'd0: r = 32'd536870912;
			5'd1: r = 32'd316933406;
			5'd2: r = 32'd167458907;
			5'd3: r = 32'd85004756;
			5'd4: r = 32'd42667331;
			5'd5: r = 32'd21354465;
			5'd6: r = 32'd10679838;
			5'd7: r = 32'd5340245;
			5'd8: r = 32'd2670163;
			5'd9: r = 32'd1335087;
			5'd10: r = 32'd667544;
			5'd11: r = 32'd333772;
			5'd12: r = 32'd166886;
			5'd13: r = 32'd83443;
			5'd14: r = 32'd41722;
			5'd15: r = 32'd20861;
			5'd16: r = 32'd10430;
			5'd17: r = 32'd5215;
			5'd18: r = 32'd2608;
			5'd19: r = 32'd1304;
			5'd20: r = 32'd652;
			5'd21: r = 32'd326;
			5'd22: r = 32'd163;
			5'd23: r = 32'd81;
			default: r = 32'd0;
		endcase
		return r;
	endfunction

endpackage

>>> hdl/vpsb_front.sv
// Input stage: accepts transactions, drops unknown commands and queues the rest.
module vpsb_front import vpsb_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [95:0] s_tdata,
	input  logic [1:0]  s_tuser,
	input  logic        s_tlast,
	output logic        q_valid,
	output item_t       q_item,
	input  logic        pop
);
	localparam int QAW = $clog2(QUEUE_DEPTH);

	item_t            buf_q [QUEUE_DEPTH];
	logic [QAW-1:0]   wr_q, rd_q;
	logic [QAW:0]     cnt_q;
	logic             push;
	item_t            in_item;

	always_comb begin
		in_item.cmd      = cmd_t'(s_tuser);
		in_item.last     = s_tlast;
		in_item.range_mm = s_tdata[15:0];
		in_item.pos_x    = s_tdata[39:16];
		in_item.pos_y    = s_tdata[63:40];
		in_item.heading  = s_tdata[79:64];
		in_item.speed    = s_tdata[95:80];
	end

	assign s_tready = (cnt_q != (QAW+1)'(QUEUE_DEPTH));
	assign push     = s_tvalid && s_tready && (in_item.cmd != CMD_NONE);
	assign q_valid  = (cnt_q != '0);
	assign q_item   = buf_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wr_q] <= in_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			cnt_q <= cnt_q + (QAW+1)'(push) - (QAW+1)'(pop);
		end
	end
endmodule

>>> hdl/vpsb_back.sv
// Execution stage: waypoint table, scan tracking, braking, CORDIC bearing and PID.
module vpsb_back import vpsb_pkg::*; #(
	parameter int SCAN_SIZE     = SCAN_SIZE_DEF,
	parameter int WINDOW_FIRST  = WINDOW_FIRST_DEF,
	parameter int WINDOW_END    = WINDOW_END_DEF,
	parameter int MAX_WAYPOINTS = MAX_WAYPOINTS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  cfg_wr_t     cfg,
	input  logic        q_valid,
	input  item_t       q_item,
	output logic        pop,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,
	output logic        m_tuser
);
	localparam int IW = $clog2(MAX_WAYPOINTS);
	localparam int CW = $clog2(MAX_WAYPOINTS + 1);
	localparam int SW = $clog2(SCAN_SIZE + 1);

	state_t state_q, state_n;

	logic [15:0] max_speed_q, decel_q, brake_spd_q, gp_q, gi_q, gd_q;
	logic [14:0] max_steer_q;

	logic [47:0] mem [MAX_WAYPOINTS];
	logic [47:0] rd_q;
	logic [IW-1:0] rd_addr;
	logic mem_we;

	logic [CW-1:0] wp_cnt_q, load_ptr_q;
	logic [IW-1:0] next_idx_q;
	logic signed [23:0] tx_q, ty_q;
	logic map_q, brake_q, lap_q, gt_q, brk_q, zero_q;
	logic [SW-1:0] scan_q;
	logic [15:0] near_q, spdsel_q;
	logic [23:0] thr_q;
	logic signed [15:0] last_spd_q, esum_q, lerr_q, err_q;
	logic signed [16:0] derr_q;
	item_t item_q;

	logic [29:0] sq_q, num_q;
	logic [31:0] nd_q;
	logic [37:0] dvd_q;
	logic [25:0] rem_q, den_q;
	logic [5:0]  cnt_q;

	logic signed [24:0] dx_q, dy_q, dxc, dyc;
	logic [49:0] d2_q;
	logic [47:0] t2_q;
	logic signed [43:0] x_q, y_q, xi, yi, xs, ys;
	logic [31:0] z_q, zr;
	logic [4:0]  it_q;
	logic signed [35:0] acc_q, ar, ang, ms;
	logic signed [33:0] prod;
	logic signed [16:0] mul_a, mul_b;

	logic [15:0] decel_e, brg;
	logic signed [15:0] err_n;
	logic signed [16:0] sum17, half17, sum_c;
	logic signed [49:0] sqx, sqy;
	logic [26:0] rs;
	logic [38:0] tsum;
	logic adv, in_win;

	assign decel_e = (decel_q == 16'd0) ? 16'd1 : decel_q;
	assign dxc = $signed({tx_q[23], tx_q}) - $signed({item_q.pos_x[23], item_q.pos_x});
	assign dyc = $signed({ty_q[23], ty_q}) - $signed({item_q.pos_y[23], item_q.pos_y});
	assign sqx = dx_q * dx_q;
	assign sqy = dy_q * dy_q;
	assign xi  = $signed({{3{dxc[24]}}, dxc, 16'd0});
	assign yi  = $signed({{3{dyc[24]}}, dyc, 16'd0});
	assign xs  = x_q >>> it_q;
	assign ys  = y_q >>> it_q;
	assign zr  = z_q + 32'h8000;
	assign brg = zero_q ? 16'd0 : zr[31:16];
	assign err_n  = $signed(brg - item_q.heading);
	assign sum17  = $signed({esum_q[15], esum_q}) + $signed({err_n[15], err_n});
	assign half17 = $signed({3'b000, max_steer_q[14:1]});
	assign sum_c  = (sum17 > half17) ? half17 : ((sum17 < -half17) ? -half17 : sum17);
	assign rs   = {rem_q, dvd_q[37]};
	assign tsum = 39'(dvd_q) + 39'd1000;
	assign ar   = acc_q + 36'sd128;
	assign ang  = ar >>> 8;
	assign ms   = $signed({21'd0, max_steer_q});
	assign prod = mul_a * mul_b;
	assign in_win = (32'(scan_q) >= 32'(WINDOW_FIRST)) && (32'(scan_q) < 32'(WINDOW_END));
	assign adv = (32'(wp_cnt_q) > 32'(next_idx_q)) &&
		(32'(wp_cnt_q) - 32'(next_idx_q) > 32'd2) &&
		(32'(next_idx_q) + 32'd1 < 32'(MAX_WAYPOINTS));

	always_comb begin
		case (state_q)
			S_PID_P: begin
				mul_a = $signed({1'b0, gp_q});
				mul_b = $signed({err_q[15], err_q});
			end
			S_PID_I: begin
				mul_a = $signed({1'b0, gi_q});
				mul_b = $signed({esum_q[15], esum_q});
			end
			default: begin
				mul_a = $signed({1'b0, gd_q});
				mul_b = derr_q;
			end
		endcase
	end

	always_comb begin
		state_n = state_q;
		case (state_q)
			S_IDLE: begin
				if (q_valid) begin
					case (q_item.cmd)
						CMD_LOAD: if (q_item.last) state_n = S_LOAD_RD;
						CMD_RANGE: if (q_item.last) state_n = S_SCAN_V2;
						CMD_ODO: if (map_q) state_n = S_ODO_D;
						default: state_n = S_IDLE;
					endcase
				end
			end
			S_LOAD_RD: state_n = S_LOAD_TGT;
			S_LOAD_TGT: state_n = S_IDLE;
			S_SCAN_V2: state_n = gt_q ? S_SCAN_T2 : S_SCAN_FIN;
			S_SCAN_T2: state_n = S_SCAN_N1;
			S_SCAN_N1: state_n = S_SCAN_N2;
			S_SCAN_N2: state_n = S_SCAN_DIV;
			S_SCAN_DIV: if (cnt_q == 6'd37) state_n = S_SCAN_FIN;
			S_SCAN_FIN: state_n = S_IDLE;
			S_ODO_D: state_n = S_ODO_X2;
			S_ODO_X2: state_n = S_ODO_Y2;
			S_ODO_Y2: state_n = S_ODO_T2;
			S_ODO_T2: state_n = S_ODO_REACH;
			S_ODO_REACH: state_n = (d2_q < {2'b00, t2_q} && adv) ? S_ODO_RD : S_COR_INIT;
			S_ODO_RD: state_n = S_ODO_TGT;
			S_ODO_TGT: state_n = S_COR_INIT;
			S_COR_INIT: state_n = S_COR_RUN;
			S_COR_RUN: if (it_q == 5'd23) state_n = S_PID_E;
			S_PID_E: state_n = S_PID_P;
			S_PID_P: state_n = S_PID_I;
			S_PID_I: state_n = S_PID_D;
			S_PID_D: state_n = S_OUT;
			S_OUT: if (!m_tvalid || m_tready) state_n = S_IDLE;
			default: state_n = S_IDLE;
		endcase
	end

	always_comb begin
		pop     = (state_q == S_IDLE) && q_valid;
		mem_we  = pop && (q_item.cmd == CMD_LOAD) && (32'(load_ptr_q) < 32'(MAX_WAYPOINTS));
		rd_addr = (state_q == S_ODO_RD) ? next_idx_q : '0;
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[load_ptr_q[IW-1:0]] <= {q_item.pos_y, q_item.pos_x};
		end
		rd_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_speed_q <= 16'd0;
			max_steer_q <= 15'd4369;
			decel_q     <= 16'd8000;
			brake_spd_q <= 16'd1380;
			gp_q        <= 16'd0;
			gi_q        <= 16'd0;
			gd_q        <= 16'd0;
		end else if (cfg.we) begin
			case (cfg.idx)
				REG_MAX_SPEED: max_speed_q <= cfg.data;
				REG_MAX_STEER: max_steer_q <= cfg.data[14:0];
				REG_MAX_DECEL: decel_q <= cfg.data;
				REG_BRAKE_SPEED: brake_spd_q <= cfg.data;
				REG_GAIN_P: gp_q <= cfg.data;
				REG_GAIN_I: gi_q <= cfg.data;
				REG_GAIN_D: gd_q <= cfg.data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: item_q <= q_item;
			S_SCAN_V2: sq_q <= 30'(30'(last_spd_q[14:0]) * 30'(last_spd_q[14:0]));
			S_SCAN_T2: num_q <= 30'(32'(sq_q) - 32'(brake_spd_q) * 32'(brake_spd_q));
			S_SCAN_N1: nd_q <= 32'(near_q) * 32'(decel_e);
			S_SCAN_N2: begin
				dvd_q <= 38'(num_q) * 38'd189;
				den_q <= 26'(decel_e) * 26'd625;
				rem_q <= '0;
			end
			S_SCAN_DIV: begin
				if (rs >= {1'b0, den_q}) begin
					rem_q <= 26'(rs - {1'b0, den_q});
					dvd_q <= {dvd_q[36:0], 1'b1};
				end else begin
					rem_q <= rs[25:0];
					dvd_q <= {dvd_q[36:0], 1'b0};
				end
			end
			S_ODO_D: begin
				dx_q <= dxc;
				dy_q <= dyc;
			end
			S_ODO_X2: d2_q <= 50'(sqx);
			S_ODO_Y2: d2_q <= d2_q + 50'(sqy);
			S_ODO_T2: t2_q <= thr_q * thr_q;
			S_COR_INIT: begin
				zero_q <= (dxc == '0) && (dyc == '0);
				if (xi < 0) begin
					x_q <= -xi;
					y_q <= -yi;
					z_q <= 32'h8000_0000;
				end else begin
					x_q <= xi;
					y_q <= yi;
					z_q <= 32'd0;
				end
			end
			S_COR_RUN: begin
				if (y_q > 0) begin
					x_q <= x_q + ys;
					y_q <= y_q - xs;
					z_q <= z_q + atan_val(it_q);
				end else begin
					x_q <= x_q - ys;
					y_q <= y_q + xs;
					z_q <= z_q - atan_val(it_q);
				end
			end
			S_PID_E: begin
				err_q  <= err_n;
				derr_q <= $signed({err_n[15], err_n}) - $signed({lerr_q[15], lerr_q});
				acc_q  <= '0;
			end
			S_PID_P, S_PID_I, S_PID_D: acc_q <= acc_q + 36'(prod);
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			wp_cnt_q   <= '0;
			load_ptr_q <= '0;
			next_idx_q <= '0;
			tx_q       <= '0;
			ty_q       <= '0;
			map_q      <= 1'b0;
			scan_q     <= '0;
			near_q     <= 16'hFFFF;
			brake_q    <= 1'b0;
			thr_q      <= 24'd1000;
			last_spd_q <= '0;
			esum_q     <= '0;
			lerr_q     <= '0;
			lap_q      <= 1'b0;
			gt_q       <= 1'b0;
			brk_q      <= 1'b0;
			spdsel_q   <= '0;
			cnt_q      <= '0;
			it_q       <= '0;
			m_tvalid   <= 1'b0;
			m_tdata    <= '0;
			m_tuser    <= 1'b0;
		end else begin
			state_q <= state_n;
			if (m_tvalid && m_tready && state_q != S_OUT) begin
				m_tvalid <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (pop) begin
						case (q_item.cmd)
							CMD_LOAD: begin
								if (q_item.last) begin
									wp_cnt_q   <= mem_we ? load_ptr_q + 1'b1 : load_ptr_q;
									load_ptr_q <= '0;
									next_idx_q <= '0;
									map_q      <= 1'b1;
								end else if (mem_we) begin
									load_ptr_q <= load_ptr_q + 1'b1;
								end
							end
							CMD_RANGE: begin
								if (in_win && q_item.range_mm < near_q) begin
									near_q <= q_item.range_mm;
								end
								if (32'(scan_q) < 32'(SCAN_SIZE)) begin
									scan_q <= scan_q + 1'b1;
								end
								gt_q <= $signed({last_spd_q[15], last_spd_q}) >
									$signed({1'b0, brake_spd_q});
							end
							CMD_ODO: begin
								if (map_q) begin
									last_spd_q <= q_item.speed;
									spdsel_q   <= brake_q ? brake_spd_q : max_speed_q;
									lap_q      <= 1'b0;
								end
							end
							default: ;
						endcase
					end
				end
				S_LOAD_TGT: begin
					tx_q <= rd_q[23:0];
					ty_q <= rd_q[47:24];
				end
				S_SCAN_V2: brk_q <= near_q < 16'd1000;
				S_SCAN_N2: begin
					brk_q <= brk_q || (40'(nd_q) * 40'd125 < 40'(num_q) * 40'd84);
					cnt_q <= '0;
				end
				S_SCAN_DIV: cnt_q <= cnt_q + 1'b1;
				S_SCAN_FIN: begin
					if (gt_q) begin
						thr_q <= (tsum > 39'hFFFFFF) ? 24'hFFFFFF : tsum[23:0];
					end
					brake_q <= brk_q;
					scan_q  <= '0;
					near_q  <= 16'hFFFF;
				end
				S_ODO_REACH: begin
					if (d2_q < {2'b00, t2_q}) begin
						if (adv) begin
							next_idx_q <= next_idx_q + 1'b1;
						end else begin
							next_idx_q <= '0;
							lap_q      <= 1'b1;
						end
					end
				end
				S_ODO_TGT: begin
					tx_q <= rd_q[23:0];
					ty_q <= rd_q[47:24];
				end
				S_COR_INIT: it_q <= '0;
				S_COR_RUN: it_q <= it_q + 1'b1;
				S_PID_E: begin
					esum_q <= sum_c[15:0];
					lerr_q <= err_n;
				end
				S_OUT: begin
					if (!m_tvalid || m_tready) begin
						m_tvalid <= 1'b1;
						m_tuser  <= lap_q;
						m_tdata[31:16] <= spdsel_q;
						if (ang > ms) begin
							m_tdata[15:0] <= ms[15:0];
						end else if (ang < -ms) begin
							m_tdata[15:0] <= 16'(-ms);
						end else begin
							m_tdata[15:0] <= ang[15:0];
						end
					end
				end
				default: ;
			endcase
		end
	end
endmodule

>>> hdl/waypoint_pid_steering_with_brake_unit.sv
// Top level of the waypoint steering unit with front-range brake.
//
// Channel   Direction  Contents
// s_*       in         tuser: command; tlast: last item; tdata: range, x, y, heading, speed
// m_*       out        tuser: lap done; tdata: steer angle, speed command
// cfg_*     in         register index and 16-bit write data
//
// A waypoint load or range sample is taken while the back end is idle; the last waypoint
// adds a table read to fetch the first target. The end of a scan runs the 38-step
// restoring divider, or skips it when the speed does not exceed the braking speed.
// An odometry update runs the 24 CORDIC iterations and may then wait on m_tready. Reset
// clears all control state; the waypoint table is not cleared.
// A four-entry queue lets input transactions land while the back end is busy or the
// output register waits on m_tready.
module waypoint_pid_steering_with_brake_unit import vpsb_pkg::*; #(
	parameter int SCAN_SIZE     = SCAN_SIZE_DEF,
	parameter int WINDOW_FIRST  = WINDOW_FIRST_DEF,
	parameter int WINDOW_END    = WINDOW_END_DEF,
	parameter int MAX_WAYPOINTS = MAX_WAYPOINTS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [95:0] s_tdata,  // range_mm, pos_x_mm, pos_y_mm, heading, speed_mm_s
	input  logic [1:0]  s_tuser,  // command
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,  // steer_angle, speed_cmd_mm_s
	output logic        m_tuser,  // lap_done
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data
);
	logic    q_valid, pop;
	item_t   q_item;
	cfg_wr_t cfg;

	assign cfg.we   = cfg_we;
	assign cfg.idx  = cfg_index;
	assign cfg.data = cfg_data;

	vpsb_front u_front (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.s_tuser(s_tuser), .s_tlast(s_tlast),
		.q_valid(q_valid), .q_item(q_item), .pop(pop)
	);

	vpsb_back #(
		.SCAN_SIZE(SCAN_SIZE), .WINDOW_FIRST(WINDOW_FIRST),
		.WINDOW_END(WINDOW_END), .MAX_WAYPOINTS(MAX_WAYPOINTS)
	) u_back (
		.clk(clk), .arst_n(arst_n), .cfg(cfg),
		.q_valid(q_valid), .q_item(q_item), .pop(pop),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	a_pop_valid: assert property (@(posedge clk) disable iff (!arst_n) pop |-> q_valid)
		else $error("queue popped while empty");

	a_steer_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ($signed(m_tdata[15:0]) <= 16'sd16384 &&
			$signed(m_tdata[15:0]) >= -16'sd16384))
		else $error("steering output beyond limit");

	a_pop_clears_room: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !s_tvalid) |=> s_tready)
		else $error("queue has no room after a pop");
endmodule
